>>> rtl/twps_pkg.sv
package twps_pkg;

  localparam int SLOT_W   = 6;
  localparam int CREDIT_W = 7;
  localparam int PRIO_W   = 6;
  localparam int RS_W     = 2;
  localparam int WORD_W   = 32;
  localparam int MASK_W   = 64;

  localparam logic [CREDIT_W-1:0] CREDIT_MAX = 7'd127;

  localparam logic [RS_W-1:0] RS_RUN   = 2'd0;
  localparam logic [RS_W-1:0] RS_SLEEP = 2'd1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_SCHED = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic restart;
    logic issue;
    logic refill_mode;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic eval_busy;
    logic need_refill;
  } dp_sts_t;

endpackage

>>> rtl/twps_ram.sv
module twps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/twps_dp.sv
module twps_dp #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  twps_pkg::dp_cmd_t                cmd,
  output twps_pkg::dp_sts_t                sts,
  input  logic [twps_pkg::SLOT_W-1:0]      in_slot,
  input  logic                             in_present,
  input  logic [twps_pkg::RS_W-1:0]        in_run_state,
  input  logic [twps_pkg::CREDIT_W-1:0]    in_counter,
  input  logic [twps_pkg::PRIO_W-1:0]      in_priority_req,
  input  logic [twps_pkg::WORD_W-1:0]      in_pending_signals,
  input  logic [twps_pkg::WORD_W-1:0]      in_blocked_signals,
  input  logic [twps_pkg::WORD_W-1:0]      in_timeout,
  input  logic [twps_pkg::WORD_W-1:0]      in_now,
  output logic [twps_pkg::SLOT_W-1:0]      out_chosen_slot,
  output logic                             out_idle_chosen,
  output logic [twps_pkg::MASK_W-1:0]      out_woken_mask,
  output logic                             out_refilled
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int ST_W  = twps_pkg::RS_W + twps_pkg::WORD_W;
  localparam int SG_W  = 2 * twps_pkg::WORD_W;
  localparam int CR_W  = twps_pkg::PRIO_W + twps_pkg::CREDIT_W;

  logic [NUM_SLOTS-1:0]              present_r;
  logic [IDX_W-1:0]                  rd_idx_r;
  logic [IDX_W-1:0]                  eval_idx_r;
  logic                              eval_vld_r;
  logic [twps_pkg::WORD_W-1:0]       now_r;
  logic [twps_pkg::MASK_W-1:0]       woken_r;
  logic                              found_r;
  logic [twps_pkg::CREDIT_W-1:0]     best_r;
  logic [IDX_W-1:0]                  best_idx_r;
  logic [twps_pkg::SLOT_W-1:0]       chosen_r;
  logic                              idle_r;
  logic [twps_pkg::MASK_W-1:0]       woken_out_r;
  logic                              refilled_r;

  logic                              load_ok;
  logic [IDX_W-1:0]                  load_idx;
  logic                              ev_present;
  logic [ST_W-1:0]                   st_rd;
  logic [SG_W-1:0]                   sg_rd;
  logic [CR_W-1:0]                   cr_rd;
  logic [twps_pkg::RS_W-1:0]         ev_rs;
  logic [twps_pkg::WORD_W-1:0]       ev_tmo;
  logic [twps_pkg::WORD_W-1:0]       ev_pend;
  logic [twps_pkg::WORD_W-1:0]       ev_blk;
  logic [twps_pkg::CREDIT_W-1:0]     ev_credit;
  logic [twps_pkg::PRIO_W-1:0]       ev_prio;
  logic                              sig_wake;
  logic                              tmo_wake;
  logic                              wake;
  logic                              runnable;
  logic                              scan_ev;
  logic                              refill_ev;
  logic [twps_pkg::CREDIT_W:0]       refill_sum;
  logic [twps_pkg::CREDIT_W-1:0]     refill_val;
  logic [twps_pkg::WORD_W-1:0]       new_tmo;

  logic                              st_we;
  logic [IDX_W-1:0]                  st_waddr;
  logic [ST_W-1:0]                   st_wdata;
  logic                              cr_we;
  logic [IDX_W-1:0]                  cr_waddr;
  logic [CR_W-1:0]                   cr_wdata;

  assign load_ok  = cmd.load && (in_slot != '0) &&
                    ({1'b0, in_slot} < (twps_pkg::SLOT_W + 1)'(NUM_SLOTS));
  assign load_idx = in_slot[IDX_W-1:0];

  assign ev_present = present_r[eval_idx_r];
  assign ev_rs      = st_rd[ST_W-1:twps_pkg::WORD_W];
  assign ev_tmo     = st_rd[twps_pkg::WORD_W-1:0];
  assign ev_pend    = sg_rd[SG_W-1:twps_pkg::WORD_W];
  assign ev_blk     = sg_rd[twps_pkg::WORD_W-1:0];
  assign ev_prio    = cr_rd[CR_W-1:twps_pkg::CREDIT_W];
  assign ev_credit  = cr_rd[twps_pkg::CREDIT_W-1:0];

  assign scan_ev   = eval_vld_r && !cmd.refill_mode;
  assign refill_ev = eval_vld_r && cmd.refill_mode;

  assign sig_wake = (ev_pend & ~ev_blk) != '0;
  assign tmo_wake = (ev_tmo != '0) && (ev_tmo < now_r);
  assign wake     = ev_present && (ev_rs == twps_pkg::RS_SLEEP) && (sig_wake || tmo_wake);
  assign runnable = ev_present && ((ev_rs == twps_pkg::RS_RUN) || wake);
  assign new_tmo  = sig_wake ? ev_tmo : '0;

  assign refill_sum = {2'b00, ev_credit[twps_pkg::CREDIT_W-1:1]} +
                      {2'b00, ev_prio};
  assign refill_val = (refill_sum > {1'b0, twps_pkg::CREDIT_MAX}) ?
                      twps_pkg::CREDIT_MAX : refill_sum[twps_pkg::CREDIT_W-1:0];

  always_comb begin
    st_we    = load_ok || (scan_ev && wake);
    st_waddr = load_ok ? load_idx : eval_idx_r;
    st_wdata = load_ok ? {in_run_state, in_timeout} : {twps_pkg::RS_RUN, new_tmo};
    cr_we    = load_ok || (refill_ev && ev_present);
    cr_waddr = load_ok ? load_idx : eval_idx_r;
    cr_wdata = load_ok ? {in_priority_req, in_counter} : {ev_prio, refill_val};
  end

  twps_ram #(.WIDTH(ST_W), .DEPTH(NUM_SLOTS)) u_st_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (rd_idx_r),
    .rd_data (st_rd)
  );

  twps_ram #(.WIDTH(SG_W), .DEPTH(NUM_SLOTS)) u_sg_ram (
    .clk     (clk),
    .wr_en   (load_ok),
    .wr_addr (load_idx),
    .wr_data ({in_pending_signals, in_blocked_signals}),
    .rd_addr (rd_idx_r),
    .rd_data (sg_rd)
  );

  twps_ram #(.WIDTH(CR_W), .DEPTH(NUM_SLOTS)) u_cr_ram (
    .clk     (clk),
    .wr_en   (cr_we),
    .wr_addr (cr_waddr),
    .wr_data (cr_wdata),
    .rd_addr (rd_idx_r),
    .rd_data (cr_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      eval_vld_r <= 1'b0;
    end else begin
      if (load_ok) begin
        present_r[load_idx] <= in_present;
      end
      eval_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= rd_idx_r;
    if (cmd.start || cmd.restart) begin
      rd_idx_r <= IDX_W'(1);
    end else if (cmd.issue && !sts.sweep_last) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
    if (cmd.start) begin
      now_r      <= in_now;
      woken_r    <= '0;
      found_r    <= 1'b0;
      best_r     <= '0;
      best_idx_r <= '0;
    end else if (scan_ev) begin
      if (wake) begin
        woken_r[eval_idx_r] <= 1'b1;
      end
      if (runnable && (!found_r || (ev_credit > best_r))) begin
        found_r    <= 1'b1;
        best_r     <= ev_credit;
        best_idx_r <= eval_idx_r;
      end
    end
    if (cmd.publish) begin
      chosen_r    <= twps_pkg::SLOT_W'(best_idx_r);
      idle_r      <= !found_r;
      woken_out_r <= woken_r;
      refilled_r  <= sts.need_refill;
    end
  end

  assign sts.sweep_last  = rd_idx_r == IDX_W'(NUM_SLOTS - 1);
  assign sts.eval_busy   = eval_vld_r;
  assign sts.need_refill = found_r && (best_r == '0);

  assign out_chosen_slot = chosen_r;
  assign out_idle_chosen = idle_r;
  assign out_woken_mask  = woken_out_r;
  assign out_refilled    = refilled_r;

endmodule

>>> rtl/twps_ctrl.sv
module twps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  output logic              out_valid,
  input  logic              out_stall,
  output twps_pkg::dp_cmd_t cmd,
  input  twps_pkg::dp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REFILL,
    S_PUBLISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   issued_r;
  logic   issued_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == twps_pkg::KIND_SCHED) begin
            cmd.start  = 1'b1;
            issued_nxt = 1'b0;
            state_nxt  = S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = !issued_r;
        if (cmd.issue && sts.sweep_last) begin
          issued_nxt = 1'b1;
        end
        if (issued_r && !sts.eval_busy) begin
          if (sts.need_refill) begin
            cmd.restart = 1'b1;
            issued_nxt  = 1'b0;
            state_nxt   = S_REFILL;
          end else begin
            state_nxt = S_PUBLISH;
          end
        end
      end
      S_REFILL: begin
        cmd.refill_mode = 1'b1;
        cmd.issue       = !issued_r;
        if (cmd.issue && sts.sweep_last) begin
          issued_nxt = 1'b1;
        end
        if (issued_r && !sts.eval_busy) begin
          state_nxt = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/task_wakeup_and_pick_scheduler_unit.sv
// After a load item the next item is accepted in the following cycle.
// A schedule item takes one sweep over the slots, or two sweeps when credits
// are refilled; each sweep reads one slot per cycle through one read port per RAM.
// Throughput is one item at a time; a finished result waits in the output register.
// Reset is synchronous and active low; it clears all presence bits and control state.
module task_wakeup_and_pick_scheduler_unit #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [twps_pkg::SLOT_W-1:0]   in_slot,
  input  logic                          in_present,
  input  logic [twps_pkg::RS_W-1:0]     in_run_state,
  input  logic [twps_pkg::CREDIT_W-1:0] in_counter,
  input  logic [twps_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [twps_pkg::WORD_W-1:0]   in_pending_signals,
  input  logic [twps_pkg::WORD_W-1:0]   in_blocked_signals,
  input  logic [twps_pkg::WORD_W-1:0]   in_timeout,
  input  logic [twps_pkg::WORD_W-1:0]   in_now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [twps_pkg::SLOT_W-1:0]   out_chosen_slot,
  output logic                          out_idle_chosen,
  output logic [twps_pkg::MASK_W-1:0]   out_woken_mask,
  output logic                          out_refilled
);

  twps_pkg::dp_cmd_t cmd;
  twps_pkg::dp_sts_t sts;

  twps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  twps_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_slot            (in_slot),
    .in_present         (in_present),
    .in_run_state       (in_run_state),
    .in_counter         (in_counter),
    .in_priority_req    (in_priority_req),
    .in_pending_signals (in_pending_signals),
    .in_blocked_signals (in_blocked_signals),
    .in_timeout         (in_timeout),
    .in_now             (in_now),
    .out_chosen_slot    (out_chosen_slot),
    .out_idle_chosen    (out_idle_chosen),
    .out_woken_mask     (out_woken_mask),
    .out_refilled       (out_refilled)
  );

endmodule
